@@ design/vbr_info_tag_parser_assert.svh @@
// ----------------------------------------------------------------------------
// VBR info tag parser assertion macros
// Immediate-implication and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef VBR_INFO_TAG_PARSER_ASSERT_SVH
`define VBR_INFO_TAG_PARSER_ASSERT_SVH

// Same-cycle implication.
`define VTP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define VTP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/vtp_pkg.sv @@
// ----------------------------------------------------------------------------
// vtp_pkg
// Shared types, constants and helpers of the VBR info tag parser.
// ----------------------------------------------------------------------------
`default_nettype none

package vtp_pkg;

    localparam int SEEK_ENTRIES = 100;

    localparam logic [7:0] FLAG_FRAMES = 8'h01;
    localparam logic [7:0] FLAG_BYTES  = 8'h02;
    localparam logic [7:0] FLAG_SEEK   = 8'h04;

    localparam logic [6:0] POS_MAGIC_END = 7'd4;
    localparam logic [6:0] POS_FLAGS     = 7'd7;
    localparam logic [6:0] POS_FIELDS    = 7'd8;
    localparam logic [6:0] FIELD_LEN     = 7'd4;
    localparam logic [6:0] POS_MAX       = 7'd127;
    localparam logic [6:0] SEEK_LEN      = 7'(SEEK_ENTRIES);

    localparam logic KIND_SEEK    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic        result_kind;
        logic [6:0]  seek_index;
        logic [7:0]  seek_value;
        logic [31:0] frame_count;
        logic [31:0] byte_count;
        logic [7:0]  flag_bits;
        logic        variable_rate;
        logic        truncated;
        logic        final_of_run;
    } vtp_result_t;

    // Results produced by one accepted byte: none, one or two, in order.
    typedef struct packed {
        logic [1:0]  count;
        vtp_result_t first;
        vtp_result_t second;
    } vtp_push_t;

    function automatic logic [7:0] magic_char(input logic [1:0] idx);
        logic [7:0] c;
        unique case (idx)
            2'd0:    c = 8'h49; // I
            2'd1:    c = 8'h6E; // n
            2'd2:    c = 8'h66; // f
            default: c = 8'h6F; // o
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

@@ design/vtp_tag_if.sv @@
// ----------------------------------------------------------------------------
// vtp_tag_if
// Byte channel into the parser: one tag byte and its end mark per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface vtp_tag_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_tag;

    modport source (output valid, output data_byte, output end_of_tag, input ready);
    modport sink   (input valid, input data_byte, input end_of_tag, output ready);
endinterface

`default_nettype wire

@@ design/vtp_result_if.sv @@
// ----------------------------------------------------------------------------
// vtp_result_if
// Result channel out of the parser: seek entries and tag summaries.
// ----------------------------------------------------------------------------
`default_nettype none

interface vtp_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [6:0]  seek_index;
    logic [7:0]  seek_value;
    logic [31:0] frame_count;
    logic [31:0] byte_count;
    logic [7:0]  flag_bits;
    logic        variable_rate;
    logic        truncated;
    logic        final_of_run;

    modport source (
        output valid, output result_kind, output seek_index, output seek_value,
        output frame_count, output byte_count, output flag_bits,
        output variable_rate, output truncated, output final_of_run,
        input ready
    );
    modport sink (
        input valid, input result_kind, input seek_index, input seek_value,
        input frame_count, input byte_count, input flag_bits,
        input variable_rate, input truncated, input final_of_run,
        output ready
    );
endinterface

`default_nettype wire

@@ design/vtp_core.sv @@
// ----------------------------------------------------------------------------
// vtp_core
// Tag field tracker: byte position, flags, count shifters and magic check;
// builds the results of each accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_core (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        data_byte,
    input  wire logic              end_of_tag,
    output vtp_pkg::vtp_push_t     push
);
    import vtp_pkg::*;

    logic [6:0]  pos_reg,    pos_next;
    logic [7:0]  flags_reg,  flags_next;
    logic [31:0] frames_reg, frames_next;
    logic [31:0] bytes_reg,  bytes_next;
    logic        match_reg,  match_next;

    logic [6:0]  start_bytes;
    logic [6:0]  start_seek;
    logic [6:0]  pos_inc;
    logic [6:0]  required;
    logic [7:0]  fl;
    logic [31:0] frames_upd;
    logic [31:0] bytes_upd;
    logic        match_upd;
    logic        seek_hit;
    logic        in_frames;
    logic        in_bytes;
    vtp_result_t seek_res;
    vtp_result_t sum_res;

    always_comb
    begin
        start_bytes = POS_FIELDS + (((flags_reg & FLAG_FRAMES) != 8'h00) ? FIELD_LEN : 7'd0);
        start_seek  = start_bytes + (((flags_reg & FLAG_BYTES) != 8'h00) ? FIELD_LEN : 7'd0);

        fl         = flags_reg;
        frames_upd = frames_reg;
        bytes_upd  = bytes_reg;
        match_upd  = match_reg;
        seek_hit   = 1'b0;

        in_frames = ((flags_reg & FLAG_FRAMES) != 8'h00) && (pos_reg < POS_FIELDS + FIELD_LEN);
        in_bytes  = ((flags_reg & FLAG_BYTES) != 8'h00) && (pos_reg >= start_bytes)
                    && (pos_reg < start_bytes + FIELD_LEN);

        if (pos_reg < POS_MAGIC_END)
        begin
            if (data_byte != magic_char(pos_reg[1:0]))
            begin
                match_upd = 1'b0;
            end
        end
        else if (pos_reg == POS_FLAGS)
        begin
            fl = data_byte;
        end
        else if (pos_reg >= POS_FIELDS)
        begin
            if (in_frames)
            begin
                frames_upd = {frames_reg[23:0], data_byte};
            end
            else if (in_bytes)
            begin
                bytes_upd = {bytes_reg[23:0], data_byte};
            end
            else if (((flags_reg & FLAG_SEEK) != 8'h00) && (pos_reg >= start_seek)
                     && (pos_reg < start_seek + SEEK_LEN))
            begin
                seek_hit = 1'b1;
            end
        end

        pos_inc = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 7'd1;

        if (pos_inc < POS_FIELDS)
        begin
            required = POS_FIELDS;
        end
        else
        begin
            required = POS_FIELDS
                     + (((fl & FLAG_FRAMES) != 8'h00) ? FIELD_LEN : 7'd0)
                     + (((fl & FLAG_BYTES)  != 8'h00) ? FIELD_LEN : 7'd0)
                     + (((fl & FLAG_SEEK)   != 8'h00) ? SEEK_LEN  : 7'd0);
        end

        seek_res               = '0;
        seek_res.result_kind   = KIND_SEEK;
        seek_res.seek_index    = pos_reg - start_seek;
        seek_res.seek_value    = data_byte;
        seek_res.final_of_run  = !end_of_tag;

        sum_res                = '0;
        sum_res.result_kind    = KIND_SUMMARY;
        sum_res.frame_count    = ((fl & FLAG_FRAMES) != 8'h00) ? frames_upd : 32'd0;
        sum_res.byte_count     = ((fl & FLAG_BYTES)  != 8'h00) ? bytes_upd  : 32'd0;
        sum_res.flag_bits      = fl;
        sum_res.variable_rate  = !(match_upd && (pos_inc >= POS_MAGIC_END));
        sum_res.truncated      = (pos_inc < required);
        sum_res.final_of_run   = 1'b1;

        push = '0;
        if (accept)
        begin
            if (seek_hit)
            begin
                push.first  = seek_res;
                push.second = sum_res;
                push.count  = end_of_tag ? 2'd2 : 2'd1;
            end
            else if (end_of_tag)
            begin
                push.first = sum_res;
                push.count = 2'd1;
            end
        end

        pos_next    = pos_reg;
        flags_next  = flags_reg;
        frames_next = frames_reg;
        bytes_next  = bytes_reg;
        match_next  = match_reg;
        if (accept)
        begin
            if (end_of_tag)
            begin
                // Restart for the next tag.
                pos_next    = '0;
                flags_next  = '0;
                frames_next = '0;
                bytes_next  = '0;
                match_next  = 1'b1;
            end
            else
            begin
                pos_next    = pos_inc;
                flags_next  = fl;
                frames_next = frames_upd;
                bytes_next  = bytes_upd;
                match_next  = match_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            flags_reg  <= '0;
            frames_reg <= '0;
            bytes_reg  <= '0;
            match_reg  <= 1'b1;
        end
        else
        begin
            pos_reg    <= pos_next;
            flags_reg  <= flags_next;
            frames_reg <= frames_next;
            bytes_reg  <= bytes_next;
            match_reg  <= match_next;
        end
    end

endmodule

`default_nettype wire

@@ design/vtp_out_queue.sv @@
// ----------------------------------------------------------------------------
// vtp_out_queue
// Small result queue: takes up to two results a cycle, sends one a cycle while the sink is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module vtp_out_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  vtp_pkg::vtp_push_t push,
    output logic               room,
    vtp_result_if.source       result
);
    import vtp_pkg::*;

    vtp_result_t               mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]         cnt_reg,    cnt_next;
    logic                      pop;
    logic [QPTR_W-1:0]         wr_ptr_2nd;
    vtp_result_t               head;

    assign head = mem[rd_ptr_reg];
    assign pop  = result.valid && result.ready;
    // Room for a full pair of results.
    assign room = (cnt_reg <= QCNT_W'(QUEUE_DEPTH - 2));
    assign wr_ptr_2nd = wr_ptr_reg + QPTR_W'(1);

    assign result.valid         = (cnt_reg != '0);
    assign result.result_kind   = head.result_kind;
    assign result.seek_index    = head.seek_index;
    assign result.seek_value    = head.seek_value;
    assign result.frame_count   = head.frame_count;
    assign result.byte_count    = head.byte_count;
    assign result.flag_bits     = head.flag_bits;
    assign result.variable_rate = head.variable_rate;
    assign result.truncated     = head.truncated;
    assign result.final_of_run  = head.final_of_run;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QPTR_W'(push.count);
        rd_ptr_next = pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + QCNT_W'(push.count) - (pop ? QCNT_W'(1) : QCNT_W'(0));
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            mem[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            mem[wr_ptr_2nd] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

@@ design/vbr_info_tag_parser.sv @@
// Results: each one is written into the result queue and offered from its head;
// the summary of a seek byte carrying the end mark follows its seek entry.
// Throughput: one byte per cycle, set by the four-entry result queue, which
// takes a byte only while it has room for two results.
// Reset: asynchronous, active low; clears position, flags, counts and queue,
// and sets the magic match.
// ----------------------------------------------------------------------------
// vbr_info_tag_parser
// Parses a VBR information tag byte by byte into seek entries and a summary.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vbr_info_tag_parser_assert.svh"

module vbr_info_tag_parser (
    input  wire logic    clk,
    input  wire logic    rst_n,
    vtp_tag_if.sink      tag,
    vtp_result_if.source result
);
    import vtp_pkg::*;

    vtp_push_t push;
    logic      room;
    logic      accept;

    assign tag.ready = room;
    assign accept    = tag.valid && tag.ready;

    vtp_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (tag.data_byte),
        .end_of_tag (tag.end_of_tag),
        .push       (push)
    );

    vtp_out_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .result (result)
    );

    `VTP_ASSERT_NOW(a_push_needs_accept, push.count != 2'd0, accept,
        "results pushed without an accepted word")
    `VTP_ASSERT_NOW(a_end_gives_summary, accept && tag.end_of_tag,
        (push.count == 2'd2 && push.second.result_kind == KIND_SUMMARY)
        || (push.count == 2'd1 && push.first.result_kind == KIND_SUMMARY),
        "end of tag without a trailing summary")
    `VTP_ASSERT_NOW(a_full_has_output, !tag.ready, result.valid,
        "input stalled while no result is offered")
    `VTP_ASSERT_NEXT(a_push_shows, push.count != 2'd0, result.valid,
        "pushed result not offered next cycle")

endmodule

`default_nettype wire

@@ verif/tb_vbr_info_tag_parser.sv @@
// ----------------------------------------------------------------------------
// tb_vbr_info_tag_parser
// Feeds VBR info tags byte by byte: a short directed table, then random tags,
// mostly well formed with random content, some cut short or overlong. Every
// result word is checked field by field against an in-bench tag parser model
// or a fixed row's expected word, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_vbr_info_tag_parser;

    import vtp_pkg::*;

    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          RANDOM_BYTES = 1000;
    localparam int          STEADY_AFTER = 850;
    localparam logic [31:0] INFO_TAG     = "Info";
    localparam logic [31:0] XING_TAG     = "Xing";

    typedef struct {
        logic [7:0]  data;
        logic        last;
        bit          fixed;
        vtp_result_t want;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;

    vtp_tag_if    tag_bus ();
    vtp_result_if result_bus ();

    vbr_info_tag_parser uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tag    (tag_bus),
        .result (result_bus)
    );

    always #5 clk = ~clk;

    // Parser model state
    logic [6:0]  pos_count;
    logic [7:0]  tag_flags;
    logic [31:0] frames_acc;
    logic [31:0] bytes_acc;
    logic        info_seen;

    vtp_result_t awaited_results[$];
    script_row_t script[$];
    int          mismatches = 0;
    int          cycles = 0;
    bit          steady = 1'b0;

    function automatic void restart_parse();
        pos_count  = '0;
        tag_flags  = '0;
        frames_acc = '0;
        bytes_acc  = '0;
        info_seen  = 1'b1;
    endfunction

    function automatic vtp_result_t make_summary(input logic [31:0] fc,
                                                 input logic [31:0] bc,
                                                 input logic [7:0] fl,
                                                 input logic vr, input logic tr);
        vtp_result_t w;
        w               = '0;
        w.result_kind   = KIND_SUMMARY;
        w.frame_count   = fc;
        w.byte_count    = bc;
        w.flag_bits     = fl;
        w.variable_rate = vr;
        w.truncated     = tr;
        w.final_of_run  = 1'b1;
        return w;
    endfunction

    function automatic void parse_tag_byte(input logic [7:0] d, input logic last,
                                           output bit has_seek,
                                           output vtp_result_t seek_word,
                                           output bit has_summary,
                                           output vtp_result_t summary_word);
        int         pos;
        int         bytes_at;
        int         seek_at;
        int         need;
        logic [7:0] fl;
        pos          = int'(pos_count);
        fl           = tag_flags;
        has_seek     = 1'b0;
        has_summary  = 1'b0;
        seek_word    = '0;
        summary_word = '0;
        bytes_at = int'(POS_FIELDS) + (((fl & FLAG_FRAMES) != 0) ? int'(FIELD_LEN) : 0);
        seek_at  = bytes_at + (((fl & FLAG_BYTES) != 0) ? int'(FIELD_LEN) : 0);

        if (pos < int'(POS_MAGIC_END)) begin
            if (d != INFO_TAG[8*(3-pos) +: 8])
                info_seen = 1'b0;
        end
        else if (pos == int'(POS_FLAGS)) begin
            tag_flags = d;
            fl        = d;
        end
        else if (pos >= int'(POS_FIELDS)) begin
            if ((fl & FLAG_FRAMES) != 0 && pos < bytes_at)
                frames_acc = {frames_acc[23:0], d};
            else if ((fl & FLAG_BYTES) != 0 && pos >= bytes_at && pos < seek_at)
                bytes_acc = {bytes_acc[23:0], d};
            else if ((fl & FLAG_SEEK) != 0 && pos >= seek_at
                     && pos < seek_at + SEEK_ENTRIES) begin
                has_seek                = 1'b1;
                seek_word.result_kind   = KIND_SEEK;
                seek_word.seek_index    = 7'(pos - seek_at);
                seek_word.seek_value    = d;
                seek_word.final_of_run  = !last;
            end
        end

        if (pos < int'(POS_MAX))
            pos++;
        pos_count = 7'(pos);

        if (last) begin
            if (pos < int'(POS_FIELDS))
                need = int'(POS_FIELDS);
            else
                need = int'(POS_FIELDS)
                     + (((fl & FLAG_FRAMES) != 0) ? int'(FIELD_LEN) : 0)
                     + (((fl & FLAG_BYTES) != 0) ? int'(FIELD_LEN) : 0)
                     + (((fl & FLAG_SEEK) != 0) ? SEEK_ENTRIES : 0);
            summary_word = make_summary(((fl & FLAG_FRAMES) != 0) ? frames_acc : 32'd0,
                                        ((fl & FLAG_BYTES) != 0) ? bytes_acc : 32'd0,
                                        fl,
                                        !(info_seen && pos >= int'(POS_MAGIC_END)),
                                        pos < need);
            has_summary = 1'b1;
            restart_parse();
        end
    endfunction

    task automatic add_row(input logic [7:0] d, input logic l, input bit fixed,
                           input vtp_result_t want);
        script_row_t row;
        row.data  = d;
        row.last  = l;
        row.fixed = fixed;
        row.want  = want;
        script.push_back(row);
    endtask

    // Offer one word, hold it until taken, then record what it should produce.
    task automatic send_byte(input logic [7:0] d, input logic l, input bit fixed,
                             input vtp_result_t want);
        bit          got_seek;
        bit          got_summary;
        vtp_result_t seek_word;
        vtp_result_t summary_word;
        if (!steady && $urandom_range(0, 5) == 0) begin
            tag_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        tag_bus.valid      <= 1'b1;
        tag_bus.data_byte  <= d;
        tag_bus.end_of_tag <= l;
        do @(posedge clk); while (!tag_bus.ready);
        parse_tag_byte(d, l, got_seek, seek_word, got_summary, summary_word);
        if (got_seek)
            awaited_results.push_back(seek_word);
        if (got_summary)
            awaited_results.push_back(fixed ? want : summary_word);
    endtask

    task automatic drain_results();
        tag_bus.valid <= 1'b0;
        do @(posedge clk); while (awaited_results.size() != 0);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    // Stimulus
    initial begin : stimulus
        int          len;
        int          need;
        int          mode;
        int          sent;
        logic [7:0]  flags;
        logic [7:0]  b;
        logic [31:0] head;
        vtp_result_t none;

        none = '0;
        restart_parse();
        rst_n              <= 1'b0;
        tag_bus.valid      <= 1'b0;
        tag_bus.data_byte  <= '0;
        tag_bus.end_of_tag <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Short magic: one byte, then the tag ends.
        add_row(8'hFF, 1'b1, 1'b1, make_summary(32'd0, 32'd0, 8'h00, 1'b1, 1'b1));
        // Full "Info" magic, ended before the flags byte.
        for (int i = 0; i < 4; i++)
            add_row(INFO_TAG[8*(3-i) +: 8], i == 3, i == 3,
                    make_summary(32'd0, 32'd0, 8'h00, 1'b0, 1'b1));
        // Seek table, first entry carries the end mark: entry then summary.
        for (int i = 0; i < 4; i++)
            add_row(INFO_TAG[8*(3-i) +: 8], 1'b0, 1'b0, none);
        for (int i = 0; i < 3; i++)
            add_row(8'h00, 1'b0, 1'b0, none);
        add_row(FLAG_SEEK, 1'b0, 1'b0, none);
        add_row(8'hFF, 1'b1, 1'b0, none);
        // Byte count cut short after three bytes.
        add_row(8'h00, 1'b0, 1'b0, none);
        for (int i = 0; i < 6; i++)
            add_row(8'hFF, 1'b0, 1'b0, none);
        add_row(FLAG_BYTES, 1'b0, 1'b0, none);
        add_row(8'hFF, 1'b0, 1'b0, none);
        add_row(8'h00, 1'b0, 1'b0, none);
        add_row(8'h80, 1'b1, 1'b1,
                make_summary(32'd0, 32'h00FF0080, FLAG_BYTES, 1'b1, 1'b1));

        foreach (script[i])
            send_byte(script[i].data, script[i].last, script[i].fixed, script[i].want);

        // Hold off until every result of the directed part is back.
        drain_results();

        sent = 0;
        while (sent < RANDOM_BYTES) begin
            mode = $urandom_range(0, 3);
            head = (mode < 2) ? INFO_TAG : (mode == 2) ? XING_TAG : $urandom();
            flags = 8'($urandom_range(0, 255));
            need = int'(POS_FIELDS)
                 + (((flags & FLAG_FRAMES) != 0) ? int'(FIELD_LEN) : 0)
                 + (((flags & FLAG_BYTES) != 0) ? int'(FIELD_LEN) : 0)
                 + (((flags & FLAG_SEEK) != 0) ? SEEK_ENTRIES : 0);
            mode = $urandom_range(0, 9);
            if (mode < 6)
                len = need + $urandom_range(0, 3);
            else if (mode < 8)
                len = $urandom_range(1, need);
            else if (mode == 8)
                len = $urandom_range(120, 160);
            else
                len = $urandom_range(1, 9);

            for (int i = 0; i < len; i++) begin
                if (i < int'(POS_MAGIC_END))
                    b = head[8*(3-i) +: 8];
                else if (i == int'(POS_FLAGS))
                    b = flags;
                else
                    b = 8'($urandom_range(0, 255));
                send_byte(b, i == len - 1, 1'b0, none);
                sent++;
                if (sent >= STEADY_AFTER)
                    steady = 1'b1;
            end

            if (!steady && $urandom_range(0, 7) == 0)
                drain_results();
        end

        drain_results();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("tb_vbr_info_tag_parser: PASS");
        else
            $display("tb_vbr_info_tag_parser: FAIL");
        $finish;
    end

    // Result sink: random stall bursts, none once the run goes steady.
    initial begin : result_sink
        int hold;
        hold = 0;
        result_bus.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
                result_bus.ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 5) == 0) begin
                hold = $urandom_range(0, 14);
                result_bus.ready <= 1'b0;
            end
            else begin
                result_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : result_check
        vtp_result_t want;
        if (rst_n === 1'b1 && result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
            if (awaited_results.size() == 0) begin
                $error("result word with none expected");
                mismatches++;
            end
            else begin
                want = awaited_results.pop_front();
                check_field("result_kind", 32'(want.result_kind),
                            32'(result_bus.result_kind));
                check_field("seek_index", 32'(want.seek_index),
                            32'(result_bus.seek_index));
                check_field("seek_value", 32'(want.seek_value),
                            32'(result_bus.seek_value));
                check_field("frame_count", want.frame_count, result_bus.frame_count);
                check_field("byte_count", want.byte_count, result_bus.byte_count);
                check_field("flag_bits", 32'(want.flag_bits),
                            32'(result_bus.flag_bits));
                check_field("variable_rate", 32'(want.variable_rate),
                            32'(result_bus.variable_rate));
                check_field("truncated", 32'(want.truncated),
                            32'(result_bus.truncated));
                check_field("final_of_run", 32'(want.final_of_run),
                            32'(result_bus.final_of_run));
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("tb_vbr_info_tag_parser: FAIL");
            $finish;
        end
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+design
design/vtp_pkg.sv
design/vtp_tag_if.sv
design/vtp_result_if.sv
design/vtp_core.sv
design/vtp_out_queue.sv
design/vbr_info_tag_parser.sv
verif/tb_vbr_info_tag_parser.sv
